### src/cti_pkg.sv
// package for the calibration table interpolator: word types, status codes
`timescale 1ns / 1ps
`default_nettype none
package cti_pkg;
  localparam int TableDepthDef = 64;
  localparam int SamplesDef    = 5;
  localparam int SampleBitsDef = 12;

  localparam int KeyW = 12;
  localparam int VolW = 24;
  localparam int VltW = 16;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_EXACT  = 3'd1,
    ST_BELOW  = 3'd2,
    ST_ABOVE  = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [5:0]      entry_index;
    logic [KeyW-1:0] entry_key;
    logic [VolW-1:0] entry_volume;
    logic [VltW-1:0] entry_voltage;
    logic            entry_last;
    logic [11:0]     sample_value;
  } in_word_t;

  typedef struct packed {
    logic [11:0]     avg_reading;
    logic [VolW-1:0] est_volume;
    logic [VltW-1:0] est_voltage;
    logic [2:0]      status;
  } out_word_t;
endpackage
`default_nettype wire

### src/cti_div.sv
// serial restoring divider, one quotient bit per cycle, signed result
`timescale 1ns / 1ps
`default_nettype none
module cti_div #(
  parameter int NumW = 38,
  parameter int DenW = 12
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            neg,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [NumW:0]        quo
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r;
  logic [DenW:0]   rem_r;
  logic [DenW-1:0] den_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r, neg_r, done_r;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  assign trial = {rem_r[DenW-1:0], q_r[NumW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
        neg_r  <= neg;
        cnt_r  <= CntW'(NumW);
      end else if (busy_r) begin
        if (!diff[DenW]) begin
          rem_r <= diff;
          q_r   <= {q_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NumW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
endmodule
`default_nettype wire

### src/calibration_table_interpolator_top.sv
// top level: sample averaging, table scan over one memory, interpolation
// an estimate follows the word that completes an average: when interpolating it scans the
//   entry_count entries and runs two 37-step serial divisions; an exact or clamped estimate
//   scans without dividing, and an empty table skips the scan
// input: load words and non-final samples are accepted back to back; one item at a time,
//   input stalls while an estimate runs or its result word waits
// the table memory is a single port ram, read one entry per cycle during the scan
// reset clears entry count, sample sum and tally; table contents stay undefined
`timescale 1ns / 1ps
`default_nettype none
module calibration_table_interpolator_top #(
  parameter int TABLE_DEPTH          = cti_pkg::TableDepthDef,
  parameter int SAMPLES_PER_ESTIMATE = cti_pkg::SamplesDef,
  parameter int SAMPLE_BITS          = cti_pkg::SampleBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cti_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cti_pkg::out_word_t     out_data
);
  import cti_pkg::*;

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int TW   = $clog2(SAMPLES_PER_ESTIMATE + 1);
  localparam int SW   = SAMPLE_BITS + $clog2(SAMPLES_PER_ESTIMATE + 1);
  localparam int SmpW = (SAMPLE_BITS < 12) ? SAMPLE_BITS : 12;
  localparam int NumW = VolW + SAMPLE_BITS + 1;
  localparam int EW   = KeyW + VolW + VltW;

  // mean = (sum * RecipM) >> RecipS, exact for every sum below 2^SW
  localparam int RecipL = $clog2(SAMPLES_PER_ESTIMATE);
  localparam int RecipS = SW + RecipL;
  localparam longint unsigned RecipM =
    ((64'd1 << RecipS) + 64'(SAMPLES_PER_ESTIMATE) - 64'd1) / 64'(SAMPLES_PER_ESTIMATE);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_RD, S_SCAN, S_PICK, S_FETCH, S_FETCH2, S_LERP,
    S_MUL, S_DGO, S_DVOL, S_DVLT, S_OUT
  } state_t;

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_r;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] sum_r;
  logic [TW-1:0] tally_r;
  logic [SW-1:0] mean_r;
  logic [CW-1:0] scan_r;
  logic [CW-1:0] n_r;
  logic          lo_ok_r, hi_ok_r, ex_ok_r;
  logic [AW-1:0] lo_r, hi_r, ex_r;
  logic [SW-1:0] lo_d_r, hi_d_r;
  logic [EW-1:0] a_r;
  logic [VolW-1:0] vol_r;
  logic [VltW-1:0] vlt_r;
  out_word_t     out_r;
  logic          ov_r;

  // sum of the finished average, divided by a reciprocal multiply
  logic [SW-1:0]   rem_r;
  logic [2*SW:0]   recip_prod;
  logic [SW-1:0]   mean_w;

  // interpolation working regs
  logic [SAMPLE_BITS:0] off_r;        // mean - lo_key
  logic [KeyW-1:0]      span_r;       // hi_key - lo_key
  logic signed [VolW:0] dvol_r;
  logic signed [VltW:0] dvlt_r;
  logic [NumW-1:0]      pvol_r, pvlt_r;
  logic                 nvol_r, nvlt_r;
  logic                 dstart;
  logic                 dneg;
  logic [NumW-1:0]      dnum;
  logic                 ddone;
  logic [NumW:0]        dquo;

  logic [SW-1:0]   k_ext;
  logic [KeyW-1:0] rd_key;
  logic [SW-1:0]   key_gap;

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  assign recip_prod = (2*SW+1)'(rem_r) * (2*SW+1)'(RecipM);
  assign mean_w     = SW'(recip_prod >> RecipS);

  assign rd_key  = rd_r[EW-1 -: KeyW];
  assign k_ext   = SW'(rd_key);
  assign key_gap = (k_ext < mean_r) ? mean_r - k_ext : k_ext - mean_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_r[AW-1:0];
    case (state_r)
      S_RD, S_SCAN: rd_en = (scan_r < n_r);
      S_FETCH:  begin rd_en = 1'b1; rd_addr = lo_r; end
      S_FETCH2: begin rd_en = 1'b1; rd_addr = hi_r; end
      S_PICK:   begin
        rd_en = 1'b1;
        rd_addr = ex_ok_r ? ex_r : (lo_ok_r ? lo_r : hi_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && in_data.cmd == CMD_LOAD &&
        32'(in_data.entry_index) < TABLE_DEPTH)
      mem[AW'(in_data.entry_index)] <=
        {in_data.entry_key, in_data.entry_volume, in_data.entry_voltage};
    if (rd_en) rd_r <= mem[rd_addr];
  end

  cti_div #(.NumW(NumW), .DenW(KeyW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .neg(dneg),
    .num(dnum), .den(span_r), .done(ddone), .quo(dquo)
  );

  always_comb begin
    dstart = 1'b0;
    dneg   = nvol_r;
    dnum   = pvol_r;
    if (state_r == S_DGO) dstart = 1'b1;
    if (state_r == S_DVOL && ddone) begin
      dstart = 1'b1; dneg = nvlt_r; dnum = pvlt_r;
    end
  end

  logic signed [NumW+1:0] v_s;
  always_comb begin
    v_s = (state_r == S_DVOL)
        ? $signed((NumW+2)'(a_r[VltW +: VolW])) + $signed({{1{dquo[NumW]}}, dquo})
        : $signed((NumW+2)'(a_r[VltW-1:0]))    + $signed({{1{dquo[NumW]}}, dquo});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sum_r   <= '0;
      tally_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (in_data.cmd == CMD_LOAD) begin
              if (32'(in_data.entry_index) < TABLE_DEPTH && in_data.entry_last)
                count_r <= CW'(in_data.entry_index) + 1'b1;
            end else if (tally_r == TW'(SAMPLES_PER_ESTIMATE - 1)) begin
              rem_r   <= sum_r + SW'(in_data.sample_value[SmpW-1:0]);
              sum_r   <= '0;
              tally_r <= '0;
              state_r <= S_DIV;
            end else begin
              sum_r   <= sum_r + SW'(in_data.sample_value[SmpW-1:0]);
              tally_r <= tally_r + 1'b1;
            end
          end
        end
        S_DIV: begin
          mean_r  <= mean_w;
          scan_r  <= '0;
          n_r     <= count_r;
          lo_ok_r <= 1'b0;
          hi_ok_r <= 1'b0;
          ex_ok_r <= 1'b0;
          if (count_r == '0) begin
            out_r   <= '{avg_reading: 12'(mean_w), est_volume: '0,
                         est_voltage: '0, status: ST_EMPTY};
            state_r <= S_OUT;
          end else state_r <= S_RD;
        end
        S_RD: begin
          scan_r  <= scan_r + 1'b1;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (k_ext == mean_r) begin
            if (!ex_ok_r) begin ex_ok_r <= 1'b1; ex_r <= AW'(scan_r - 1'b1); end
          end else if (k_ext < mean_r) begin
            if (!lo_ok_r || key_gap < lo_d_r) begin
              lo_ok_r <= 1'b1; lo_r <= AW'(scan_r - 1'b1); lo_d_r <= key_gap;
            end
          end else begin
            if (!hi_ok_r || key_gap < hi_d_r) begin
              hi_ok_r <= 1'b1; hi_r <= AW'(scan_r - 1'b1); hi_d_r <= key_gap;
            end
          end
          if (scan_r == n_r) state_r <= S_PICK;
          else scan_r <= scan_r + 1'b1;
        end
        S_PICK: begin
          if (ex_ok_r || !lo_ok_r || !hi_ok_r) state_r <= S_LERP;
          else state_r <= S_FETCH;
        end
        S_FETCH: state_r <= S_FETCH2;
        S_FETCH2: begin
          a_r <= rd_r;
          state_r <= S_LERP;
        end
        S_LERP: begin
          if (ex_ok_r || !lo_ok_r || !hi_ok_r) begin
            out_r <= '{avg_reading: 12'(mean_r),
                       est_volume: rd_r[VltW +: VolW], est_voltage: rd_r[VltW-1:0],
                       status: ex_ok_r ? ST_EXACT : (!lo_ok_r ? ST_BELOW : ST_ABOVE)};
            state_r <= S_OUT;
          end else begin
            off_r  <= (SAMPLE_BITS+1)'(mean_r - SW'(a_r[EW-1 -: KeyW]));
            span_r <= rd_key - a_r[EW-1 -: KeyW];
            dvol_r <= $signed({1'b0, rd_r[VltW +: VolW]}) - $signed({1'b0, a_r[VltW +: VolW]});
            dvlt_r <= $signed({1'b0, rd_r[VltW-1:0]}) - $signed({1'b0, a_r[VltW-1:0]});
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_DGO;
        // products are registered now, start the volume division
        S_DGO: state_r <= S_DVOL;
        S_DVOL: begin
          if (ddone) begin
            if (v_s < 0) vol_r <= '0;
            else if (v_s > $signed((NumW+2)'({VolW{1'b1}}))) vol_r <= '1;
            else vol_r <= v_s[VolW-1:0];
            state_r <= S_DVLT;
          end
        end
        S_DVLT: begin
          if (ddone) begin
            out_r.avg_reading <= 12'(mean_r);
            out_r.est_volume  <= vol_r;
            out_r.status      <= ST_INTERP;
            if (v_s < 0) out_r.est_voltage <= '0;
            else if (v_s > $signed((NumW+2)'({VltW{1'b1}}))) out_r.est_voltage <= '1;
            else out_r.est_voltage <= v_s[VltW-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          ov_r    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // magnitudes of the products, one multiply each, registered before the divider
  logic [VolW-1:0] avol;
  logic [VltW-1:0] avlt;
  assign avol = dvol_r[VolW] ? VolW'(-dvol_r) : VolW'(dvol_r);
  assign avlt = dvlt_r[VltW] ? VltW'(-dvlt_r) : VltW'(dvlt_r);
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      pvol_r <= NumW'(off_r) * NumW'(avol);
      pvlt_r <= NumW'(off_r) * NumW'(avlt);
      nvol_r <= dvol_r[VolW];
      nvlt_r <= dvlt_r[VltW];
    end
  end
endmodule
`default_nettype wire

### bench/calibration_table_interpolator_top_tb.sv
// testbench for the calibration table interpolator: directed table, random episodes, predictor
`timescale 1ns / 1ps
`default_nettype none
module calibration_table_interpolator_top_tb;
  import cti_pkg::*;

  localparam int Depth    = 64;
  localparam int Avg      = 5;
  localparam int NRandom  = 1400;
  localparam int Drain    = 200;
  localparam int DogLimit = 20000;
  localparam int InW      = $bits(in_word_t);

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  calibration_table_interpolator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic [KeyW-1:0] tbl_key [Depth];
  logic [VolW-1:0] tbl_vol [Depth];
  logic [VltW-1:0] tbl_vlt [Depth];
  int unsigned     n_entries;
  int unsigned     acc_sum;
  int unsigned     acc_tally;

  // generator shadow, keeps loads from exposing unwritten slots and supplies keys as sample bases
  bit              gen_written [Depth];
  int unsigned     gen_count;
  logic [KeyW-1:0] gen_key [Depth];

  out_word_t expected_q[$];
  in_word_t  plan_q[$];
  int        mismatches = 0;
  int        dog = 0;
  bit        calm;
  bit        timed_out = 1'b0;
  bit        accept_in;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] lerp(int unsigned mean, int unsigned klo, int unsigned khi,
                                       int unsigned vlo, int unsigned vhi, int unsigned vmax);
    longint num;
    longint v;
    num = longint'(mean - klo) * (longint'(vhi) - longint'(vlo));
    v = longint'(vlo) + num / (longint'(khi) - longint'(klo));
    if (v < 0) return 0;
    if (v > longint'(vmax)) return vmax;
    return v[31:0];
  endfunction

  // returns 1 and the estimate when this word completes an average
  function automatic bit estimate(in_word_t w, output out_word_t r);
    int unsigned mean, ld, hd;
    int lo, hi, ex;
    if (w.cmd == CMD_LOAD) begin
      tbl_key[w.entry_index] = w.entry_key;
      tbl_vol[w.entry_index] = w.entry_volume;
      tbl_vlt[w.entry_index] = w.entry_voltage;
      if (w.entry_last) n_entries = 32'(w.entry_index) + 1;
      return 0;
    end
    acc_sum += 32'(w.sample_value);
    acc_tally++;
    if (acc_tally < Avg) return 0;
    mean = acc_sum / Avg;
    acc_sum = 0;
    acc_tally = 0;
    r = '0;
    r.avg_reading = mean[11:0];
    if (n_entries == 0) begin
      r.status = ST_EMPTY;
      return 1;
    end
    lo = -1; hi = -1; ex = -1; ld = 0; hd = 0;
    for (int i = 0; i < n_entries; i++) begin
      if (32'(tbl_key[i]) == mean) begin
        if (ex < 0) ex = i;
      end else if (32'(tbl_key[i]) < mean) begin
        if (lo < 0 || mean - 32'(tbl_key[i]) < ld) begin
          lo = i; ld = mean - 32'(tbl_key[i]);
        end
      end else if (hi < 0 || 32'(tbl_key[i]) - mean < hd) begin
        hi = i; hd = 32'(tbl_key[i]) - mean;
      end
    end
    if (ex >= 0) begin
      r.status = ST_EXACT; r.est_volume = tbl_vol[ex]; r.est_voltage = tbl_vlt[ex];
    end else if (lo < 0) begin
      r.status = ST_BELOW; r.est_volume = tbl_vol[hi]; r.est_voltage = tbl_vlt[hi];
    end else if (hi < 0) begin
      r.status = ST_ABOVE; r.est_volume = tbl_vol[lo]; r.est_voltage = tbl_vlt[lo];
    end else begin
      r.status = ST_INTERP;
      r.est_volume = VolW'(lerp(mean, 32'(tbl_key[lo]), 32'(tbl_key[hi]),
                                32'(tbl_vol[lo]), 32'(tbl_vol[hi]), 32'hFFFFFF));
      r.est_voltage = VltW'(lerp(mean, 32'(tbl_key[lo]), 32'(tbl_key[hi]),
                                 32'(tbl_vlt[lo]), 32'(tbl_vlt[hi]), 32'hFFFF));
    end
    return 1;
  endfunction

  function automatic in_word_t load_word(int idx, int key, int vol, int vlt, bit last);
    in_word_t w;
    w = '0;
    w.cmd = CMD_LOAD;
    w.entry_index = 6'(idx);
    w.entry_key = KeyW'(key);
    w.entry_volume = VolW'(vol);
    w.entry_voltage = VltW'(vlt);
    w.entry_last = last;
    w.sample_value = 12'($urandom);
    gen_written[idx] = 1'b1;
    gen_key[idx] = KeyW'(key);
    if (last) gen_count = idx + 1;
    return w;
  endfunction

  function automatic in_word_t sample_word(int v);
    in_word_t w;
    w = InW'({$urandom, $urandom, $urandom});
    w.cmd = CMD_SAMPLE;
    w.sample_value = 12'(v);
    return w;
  endfunction

  function automatic int rand_key(bit coarse);
    return coarse ? $urandom_range(0, 15) * 256 : $urandom_range(0, 4095);
  endfunction

  // queues one episode of random items
  task automatic plan_episode();
    int sel, n, base, idx;
    bit coarse, ok;
    sel = $urandom_range(0, 9);
    if (sel <= 1) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, Depth) : $urandom_range(1, 8);
      coarse = $urandom_range(0, 1);
      for (int i = 0; i < n; i++)
        plan_q.push_back(load_word(i, rand_key(coarse), $urandom, $urandom, i == n - 1));
    end else if (sel <= 7) begin
      if (gen_count > 0 && $urandom_range(0, 2) == 0) begin
        base = int'(gen_key[$urandom_range(0, gen_count - 1)]);
        repeat (Avg) plan_q.push_back(sample_word(base));
      end else if ($urandom_range(0, 1)) begin
        base = $urandom_range(0, 4095);
        repeat (Avg) plan_q.push_back(sample_word(base ^ $urandom_range(0, 7)));
      end else begin
        repeat (Avg) plan_q.push_back(sample_word($urandom_range(0, 4095)));
      end
    end else if (sel == 8) begin
      idx = $urandom_range(0, Depth - 1);
      ok = 1'b1;
      for (int i = 0; i < idx; i++) if (!gen_written[i]) ok = 1'b0;
      plan_q.push_back(load_word(idx, rand_key($urandom_range(0, 1)), $urandom, $urandom,
                                 ok && $urandom_range(0, 1)));
    end else begin
      plan_q.push_back(sample_word($urandom_range(0, 4095)));
    end
  endtask

  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    out_word_t r;
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (estimate(w, r)) expected_q.push_back(typed ? want : r);
  endtask

  task automatic wait_empty();
    while (expected_q.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // out_stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 30);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data.avg_reading !== want.avg_reading ||
              out_data.est_volume !== want.est_volume ||
              out_data.est_voltage !== want.est_voltage ||
              out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %h %h %0d got %0d %h %h %0d",
                       want.avg_reading, want.est_volume, want.est_voltage, want.status,
                       out_data.avg_reading, out_data.est_volume, out_data.est_voltage,
                       out_data.status);
          end
        end
      end
      accept_in = in_valid && !in_stall;
      if (accept_in || (out_valid && !out_stall)) dog <= 0;
      else dog <= dog + 1;
      if (dog >= DogLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("calibration_table_interpolator_top test failed");
        $finish;
      end
    end
  end

  stim_row_t rows[$];

  task automatic add_row(in_word_t w, bit typed = 0, int avg = 0, int vol = 0, int vlt = 0,
                         status_t st = ST_INTERP);
    stim_row_t s;
    s.w = w;
    s.typed = typed;
    s.res = '{avg_reading: 12'(avg), est_volume: VolW'(vol), est_voltage: VltW'(vlt),
              status: st};
    rows.push_back(s);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    n_entries = 0; acc_sum = 0; acc_tally = 0;
    gen_count = 0;
    calm = 0;
    foreach (gen_written[i]) gen_written[i] = 1'b0;

    // empty table, then clamping at both ends and an exact hit
    repeat (4) add_row(sample_word(0));
    add_row(sample_word(0), 1, 0, 0, 0, ST_EMPTY);
    add_row(load_word(0, 1000, 24'h000100, 16'h0100, 0));
    add_row(load_word(1, 3000, 24'hFFFFFF, 16'hFFFF, 1));
    repeat (4) add_row(sample_word(4095));
    add_row(sample_word(4095), 1, 4095, 24'hFFFFFF, 16'hFFFF, ST_ABOVE);
    repeat (4) add_row(sample_word(0));
    add_row(sample_word(0), 1, 0, 24'h000100, 16'h0100, ST_BELOW);
    repeat (4) add_row(sample_word(1000));
    add_row(sample_word(1000), 1, 1000, 24'h000100, 16'h0100, ST_EXACT);
    repeat (3) add_row(sample_word(2000));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

    for (int n = 0; n < NRandom; n++) begin
      if (plan_q.size() == 0) plan_episode();
      calm = (n >= 500 && n < 700);
      if (n == 900) begin
        in_valid <= 1'b0;
        wait_empty();
        repeat (Drain) @(posedge clk);
      end
      send_word(plan_q.pop_front(), 0, '0);
    end
    in_valid <= 1'b0;
    wait_empty();
    repeat (Drain) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("calibration_table_interpolator_top test passed");
    else
      $display("calibration_table_interpolator_top test failed");
    $finish;
  end
endmodule
`default_nettype wire

### calibration_table_interpolator_top.f
src/cti_pkg.sv
src/cti_div.sv
src/calibration_table_interpolator_top.sv
bench/calibration_table_interpolator_top_tb.sv
